// ===== rtl/qsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsc_pkg
// Shared constants, quarter-wave sine table and pipeline payload types.
// ----------------------------------------------------------------------------
package qsc_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int ROM_DEPTH     = 256;
   localparam int TBL_LG        = (TABLE_ENTRIES >= 256) ? 8 :
                                  (TABLE_ENTRIES >= 128) ? 7 :
                                  (TABLE_ENTRIES >= 64)  ? 6 :
                                  (TABLE_ENTRIES >= 32)  ? 5 : 4;
   localparam int ROM_SHIFT     = 8 - TBL_LG;
   localparam int FRAC_W        = 14 - TBL_LG;
   localparam int PCT_SHIFT     = 15 - FRAC_W;

   localparam int DIV_BITS      = 15;
   localparam int DIV_STEP      = 3;
   localparam int DIV_STAGES    = DIV_BITS / DIV_STEP;

   localparam logic [1:0] CMD_SIN = 2'd0;
   localparam logic [1:0] CMD_COS = 2'd1;
   localparam logic [1:0] CMD_TAN = 2'd2;

   localparam logic [15:0] QUARTER_TURN = 16'd16384;
   localparam logic signed [15:0] POS_FULL = 16'sh7FFF;
   localparam logic signed [15:0] NEG_FULL = 16'sh8000;
   localparam logic [14:0] TOP_ENTRY = 15'd32767;

   localparam logic [14:0] QSC_ROM [ROM_DEPTH] = '{
      15'd0, 15'd201, 15'd402, 15'd603, 15'd804, 15'd1005, 15'd1206, 15'd1406,
      15'd1607, 15'd1808, 15'd2009, 15'd2209, 15'd2410, 15'd2610, 15'd2811, 15'd3011,
      15'd3211, 15'd3411, 15'd3611, 15'd3811, 15'd4011, 15'd4210, 15'd4409, 15'd4608,
      15'd4807, 15'd5006, 15'd5205, 15'd5403, 15'd5601, 15'd5799, 15'd5997, 15'd6195,
      15'd6392, 15'd6589, 15'd6786, 15'd6982, 15'd7179, 15'd7375, 15'd7571, 15'd7766,
      15'd7961, 15'd8156, 15'd8351, 15'd8545, 15'd8739, 15'd8932, 15'd9126, 15'd9319,
      15'd9511, 15'd9703, 15'd9895, 15'd10087, 15'd10278, 15'd10469, 15'd10659, 15'd10849,
      15'd11038, 15'd11227, 15'd11416, 15'd11604, 15'd11792, 15'd11980, 15'd12166, 15'd12353,
      15'd12539, 15'd12724, 15'd12909, 15'd13094, 15'd13278, 15'd13462, 15'd13645, 15'd13827,
      15'd14009, 15'd14191, 15'd14372, 15'd14552, 15'd14732, 15'd14911, 15'd15090, 15'd15268,
      15'd15446, 15'd15623, 15'd15799, 15'd15975, 15'd16150, 15'd16325, 15'd16499, 15'd16672,
      15'd16845, 15'd17017, 15'd17189, 15'd17360, 15'd17530, 15'd17699, 15'd17868, 15'd18036,
      15'd18204, 15'd18371, 15'd18537, 15'd18702, 15'd18867, 15'd19031, 15'd19194, 15'd19357,
      15'd19519, 15'd19680, 15'd19840, 15'd20000, 15'd20159, 15'd20317, 15'd20474, 15'd20631,
      15'd20787, 15'd20942, 15'd21096, 15'd21249, 15'd21402, 15'd21554, 15'd21705, 15'd21855,
      15'd22004, 15'd22153, 15'd22301, 15'd22448, 15'd22594, 15'd22739, 15'd22883, 15'd23027,
      15'd23169, 15'd23311, 15'd23452, 15'd23592, 15'd23731, 15'd23869, 15'd24006, 15'd24143,
      15'd24278, 15'd24413, 15'd24546, 15'd24679, 15'd24811, 15'd24942, 15'd25072, 15'd25201,
      15'd25329, 15'd25456, 15'd25582, 15'd25707, 15'd25831, 15'd25954, 15'd26077, 15'd26198,
      15'd26318, 15'd26437, 15'd26556, 15'd26673, 15'd26789, 15'd26905, 15'd27019, 15'd27132,
      15'd27244, 15'd27355, 15'd27466, 15'd27575, 15'd27683, 15'd27790, 15'd27896, 15'd28001,
      15'd28105, 15'd28208, 15'd28309, 15'd28410, 15'd28510, 15'd28608, 15'd28706, 15'd28802,
      15'd28897, 15'd28992, 15'd29085, 15'd29177, 15'd29268, 15'd29358, 15'd29446, 15'd29534,
      15'd29621, 15'd29706, 15'd29790, 15'd29873, 15'd29955, 15'd30036, 15'd30116, 15'd30195,
      15'd30272, 15'd30349, 15'd30424, 15'd30498, 15'd30571, 15'd30643, 15'd30713, 15'd30783,
      15'd30851, 15'd30918, 15'd30984, 15'd31049, 15'd31113, 15'd31175, 15'd31236, 15'd31297,
      15'd31356, 15'd31413, 15'd31470, 15'd31525, 15'd31580, 15'd31633, 15'd31684, 15'd31735,
      15'd31785, 15'd31833, 15'd31880, 15'd31926, 15'd31970, 15'd32014, 15'd32056, 15'd32097,
      15'd32137, 15'd32176, 15'd32213, 15'd32249, 15'd32284, 15'd32318, 15'd32350, 15'd32382,
      15'd32412, 15'd32441, 15'd32468, 15'd32495, 15'd32520, 15'd32544, 15'd32567, 15'd32588,
      15'd32609, 15'd32628, 15'd32646, 15'd32662, 15'd32678, 15'd32692, 15'd32705, 15'd32717,
      15'd32727, 15'd32736, 15'd32744, 15'd32751, 15'd32757, 15'd32761, 15'd32764, 15'd32766
   };

   // payload of one divider stage; bypass fields ride along
   typedef struct packed {
      logic [14:0]        rem;
      logic [14:0]        dvs;
      logic [14:0]        quo;
      logic               neg;
      logic               tan;
      logic               sat;
      logic signed [15:0] res;
   } div_type;

   typedef struct packed {
      logic a;
      logic b;
   } sine_en_type;

endpackage

// ===== rtl/qsc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsc_req_if / qsc_rsp_if
// Valid/ready channels for request and response beats.
// ----------------------------------------------------------------------------
interface qsc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [15:0] angle;
   modport source (output valid, output cmd, output angle, input ready);
   modport sink   (input valid, input cmd, input angle, output ready);
endinterface

interface qsc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] result;
   logic               saturated;
   modport source (output valid, output result, output saturated, input ready);
   modport sink   (input valid, input result, input saturated, output ready);
endinterface

// ===== rtl/qsc_sine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsc_sine
// Two-stage full-wave sine: table lookup, then interpolate and sign.
// ----------------------------------------------------------------------------
module qsc_sine
   import qsc_pkg::*;
(
   input  logic               clock,
   input  sine_en_type        en,
   input  logic [15:0]        angle,
   input  logic               interp,
   output logic signed [15:0] value
);

   logic [13:0]       arg;
   logic [TBL_LG-1:0] idx;
   logic [TBL_LG-1:0] idx_nx;
   logic [14:0]       v0;
   logic [14:0]       v1;
   logic [FRAC_W-1:0] frac;

   logic [14:0] v0_ff, v0_in;
   logic [14:0] diff_ff, diff_in;
   logic [14:0] pct_ff, pct_in;
   logic        neg_ff, neg_in;
   logic        interp_ff, interp_in;
   logic signed [15:0] value_ff, value_in;

   logic [29:0] prod;
   logic [15:0] mag;

   always_comb begin
      // mirror odd quadrants
      arg    = angle[14] ? ~angle[13:0] : angle[13:0];
      idx    = arg[13:FRAC_W];
      frac   = arg[FRAC_W-1:0];
      idx_nx = idx + 1'b1;
      v0     = QSC_ROM[8'(8'(idx) << ROM_SHIFT)];
      v1     = (&idx) ? TOP_ENTRY : QSC_ROM[8'(8'(idx_nx) << ROM_SHIFT)];
      v0_in     = v0;
      diff_in   = v1 - v0;
      pct_in    = 15'(15'(frac) << PCT_SHIFT);
      neg_in    = angle[15];
      interp_in = interp;
   end

   always_comb begin
      prod = pct_ff * diff_ff;
      mag  = {1'b0, v0_ff};
      if (interp_ff) begin
         mag = {1'b0, v0_ff} + {1'b0, prod[29:15]};
      end
      value_in = neg_ff ? -$signed(mag) : $signed(mag);
   end

   always_ff @(posedge clock) begin
      if (en.a) begin
         v0_ff     <= v0_in;
         diff_ff   <= diff_in;
         pct_ff    <= pct_in;
         neg_ff    <= neg_in;
         interp_ff <= interp_in;
      end
      if (en.b) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

// ===== rtl/qsc_div_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsc_div_stage
// One registered slice of the restoring divider for the tangent quotient.
// ----------------------------------------------------------------------------
module qsc_div_stage
   import qsc_pkg::*;
(
   input  logic    clock,
   input  logic    en,
   input  div_type din,
   output div_type dout
);

   div_type     dout_ff, dout_in;
   logic [15:0] r2;

   always_comb begin
      dout_in = din;
      r2      = '0;
      for (int k = 0; k < DIV_STEP; k++) begin
         r2 = {dout_in.rem, 1'b0};
         if (r2 >= {1'b0, dout_in.dvs}) begin
            dout_in.rem = 15'(r2 - {1'b0, dout_in.dvs});
            dout_in.quo = {dout_in.quo[13:0], 1'b1};
         end else begin
            dout_in.rem = r2[14:0];
            dout_in.quo = {dout_in.quo[13:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dout_ff <= dout_in;
      end
   end

   assign dout = dout_ff;

endmodule

// ===== rtl/q15_sin_cos_tan_unit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q15_sin_cos_tan_unit_core
// Q15 sine, cosine and tangent of a 16-bit angle, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries cmd (0 sin, 1 cos, 2 tan) and a 16-bit angle, 65536 a turn.
//   rsp_ch returns a Q15 result and a saturated flag (tangent clipped).
//   csr_wr_en/csr_wr_data write the interpolate bit; write it only while idle.
// Throughput: one beat per cycle while rsp_ch.ready is high; each of the 9 stages holds one item.
//   Stages: table lookup, interpolation multiply, tangent setup, five divider
//   slices of three quotient bits each, output register.
// Stall: a stage advances when it is empty or the stage after it moves, so
//   bubbles collapse and req_ch.ready stays high while any stage is empty.
//   Nothing is dropped or repeated while rsp_ch.ready is low.
// Reset: clears all stage valid bits and sets interpolate to 1.
// ----------------------------------------------------------------------------
module q15_sin_cos_tan_unit_core
   import qsc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   qsc_req_if.sink          req_ch,
   qsc_rsp_if.source        rsp_ch,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data
);

   localparam int NUM_STAGES = 3 + DIV_STAGES + 1;
   localparam int OUT_STAGE  = NUM_STAGES - 1;

   logic                  interp_ff;
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES:0]   adv;
   logic [1:0]            cmd_a_ff;
   logic [1:0]            cmd_b_ff;
   sine_en_type           sine_en;
   logic signed [15:0]    sin_val;
   logic signed [15:0]    cos_val;
   logic [15:0]           cos_angle;

   div_type            prep_in;
   div_type            div_q [DIV_STAGES+1];
   logic [14:0]        abs_s;
   logic [14:0]        abs_c;
   logic signed [15:0] result_ff, result_in;
   logic               sat_ff, sat_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         interp_ff <= 1'b1;
      end else if (csr_wr_en) begin
         interp_ff <= csr_wr_data;
      end
   end

   // advance chain: a stage moves when empty or when its successor moves
   always_comb begin
      adv[NUM_STAGES] = rsp_ch.ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_ch.valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign req_ch.ready = adv[0];
   assign sine_en      = '{a: adv[0], b: adv[1]};
   assign cos_angle    = req_ch.angle + QUARTER_TURN;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         cmd_a_ff <= req_ch.cmd;
      end
      if (adv[1]) begin
         cmd_b_ff <= cmd_a_ff;
      end
   end

   qsc_sine u_sin (
      .clock  (clock),
      .en     (sine_en),
      .angle  (req_ch.angle),
      .interp (interp_ff),
      .value  (sin_val)
   );

   qsc_sine u_cos (
      .clock  (clock),
      .en     (sine_en),
      .angle  (cos_angle),
      .interp (interp_ff),
      .value  (cos_val)
   );

   // tangent setup: saturate test, magnitudes, quotient sign
   always_comb begin
      abs_s       = sin_val[15] ? 15'(-sin_val) : sin_val[14:0];
      abs_c       = cos_val[15] ? 15'(-cos_val) : cos_val[14:0];
      prep_in     = '0;
      prep_in.rem = abs_s;
      prep_in.dvs = abs_c;
      prep_in.neg = sin_val[15] ^ cos_val[15];
      unique case (cmd_b_ff)
         CMD_SIN: prep_in.res = sin_val;
         CMD_COS: prep_in.res = cos_val;
         CMD_TAN: begin
            prep_in.tan = 1'b1;
            if (abs_s >= abs_c) begin
               prep_in.sat = 1'b1;
               prep_in.res = prep_in.neg ? NEG_FULL : POS_FULL;
            end
         end
         default: prep_in.res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         div_q[0] <= prep_in;
      end
   end

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      qsc_div_stage u_div (
         .clock (clock),
         .en    (adv[3+g]),
         .din   (div_q[g]),
         .dout  (div_q[g+1])
      );
   end

   always_comb begin
      result_in = div_q[DIV_STAGES].res;
      sat_in    = div_q[DIV_STAGES].sat;
      if (div_q[DIV_STAGES].tan && !div_q[DIV_STAGES].sat) begin
         result_in = div_q[DIV_STAGES].neg ? -$signed({1'b0, div_q[DIV_STAGES].quo})
                                          : $signed({1'b0, div_q[DIV_STAGES].quo});
      end
   end

   always_ff @(posedge clock) begin
      if (adv[OUT_STAGE]) begin
         result_ff <= result_in;
         sat_ff    <= sat_in;
      end
   end

   assign rsp_ch.valid     = valid_ff[OUT_STAGE];
   assign rsp_ch.result    = result_ff;
   assign rsp_ch.saturated = sat_ff;

   // a ready sink never backs up into the request side
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.ready |-> req_ch.ready)
      else $error("request stalled while response side is ready");

   // a clipped tangent is always full scale
   a_sat_full: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.saturated |->
         (rsp_ch.result == POS_FULL) || (rsp_ch.result == NEG_FULL))
      else $error("saturated response is not full scale");

   // sine magnitudes never reach negative full scale
   a_sine_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |-> (sin_val != NEG_FULL) && (cos_val != NEG_FULL))
      else $error("sine value out of Q15 range");

endmodule
